/* rtl/core/comb_sort_rule_of_eleven_defines.svh */
// ----------------------------------------------------------------------------
// comb_sort_rule_of_eleven_defines
// Assertion macros shared by the comb sort block. Define ASSERT_OFF to drop
// every check from elaboration.
// ----------------------------------------------------------------------------
`ifndef COMB_SORT_RULE_OF_ELEVEN_DEFINES_SVH
`define COMB_SORT_RULE_OF_ELEVEN_DEFINES_SVH

`ifndef ASSERT_OFF
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// consequent must hold in the cycle the antecedent holds
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`endif

`endif

/* rtl/core/cs11_pkg.sv */
// ----------------------------------------------------------------------------
// cs11_pkg
// Types and fixed constants of the comb sort block.
// ----------------------------------------------------------------------------
package cs11_pkg;

	// width of the read index field
	localparam int unsigned IDX_W = 10;

	// gap shrink factor 10/13 and the rule of eleven
	localparam int unsigned GAP_NUM    = 10;
	localparam int unsigned GAP_DEN    = 13;
	localparam int unsigned GAP_SKIP_A = 9;
	localparam int unsigned GAP_SKIP_B = 10;
	localparam int unsigned GAP_ELEVEN = 11;

	// function codes carried in tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// sort sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHRINK_MUL,
		ST_SHRINK_FIX,
		ST_PASS,
		ST_CMP,
		ST_WRJ
	} sort_state_t;

endpackage

/* rtl/core/comb_sort_rule_of_eleven.sv */
// ----------------------------------------------------------------------------
// comb_sort_rule_of_eleven
// Loads signed elements into an element RAM, sorts them in place ascending
// with comb sort (gap shrink 10/13, gaps 9 and 10 become 11) when the last
// element arrives, and serves indexed reads of the sorted set.
//
// channel  dir  tdata                             tuser               tlast
// s_axis   in   element_value, read_index         func                is_last
// m_axis   out  sorted_value                      index_out_of_range  -
//
// load: one cycle. read: result in the output register one cycle after the
// transaction, next transaction one cycle after that at the earliest.
// sort: per pass a gap update (SHRINK_MUL, SHRINK_FIX), first pair read and
// pass end (PASS), then a CMP per compare plus a WRJ and a PASS per swap. A
// 1024-element set takes roughly 25 passes. Reset needs no clearing pass.
// tready is low during the sort, while a read is in flight, and while a
// result waits that is not being taken.
// ----------------------------------------------------------------------------
`include "comb_sort_rule_of_eleven_defines.svh"

module comb_sort_rule_of_eleven #(
	parameter int unsigned MAX_ELEMENTS  = 1024,
	parameter int unsigned ELEMENT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// element_value [ELEMENT_WIDTH-1:0], read_index next 10 bits, zero fill
	input  logic [((ELEMENT_WIDTH+cs11_pkg::IDX_W+7)/8)*8-1:0] s_axis_tdata,
	// func
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// sorted_value [ELEMENT_WIDTH-1:0], zero fill
	output logic [((ELEMENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// index_out_of_range
	output logic m_axis_tuser
);

	import cs11_pkg::*;

	localparam int unsigned EW    = ELEMENT_WIDTH;
	localparam int unsigned OUT_W = ((EW + 7) / 8) * 8;
	localparam int unsigned AW    = $clog2(MAX_ELEMENTS);
	localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned CMP_W = (CW > IDX_W) ? CW : IDX_W;
	localparam int unsigned XW    = CW + 4;
	// floor(2^XW / 13): quotient estimate is exact or one low
	localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / GAP_DEN);

	sort_state_t state_q, state_d;

	logic [CW-1:0]   cnt_q;
	logic            start_q;
	logic [CW-1:0]   gap_q;
	logic [CW-1:0]   i_q;
	logic            swapped_q;
	logic [EW-1:0]   hold_q;
	logic [2*XW-1:0] prod_s1;
	logic            rd_pend_q;
	logic            rd_oor_q;
	logic            out_valid_q;
	logic [EW-1:0]   out_data_q;
	logic            out_oor_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [EW-1:0]   ram_wdata;
	logic [AW-1:0]   ram_raddr_a;
	logic [AW-1:0]   ram_raddr_b;
	logic [EW-1:0]   ram_rdata_a;
	logic [EW-1:0]   ram_rdata_b;

	logic            acc;
	logic            is_load;
	logic            is_read;
	logic [EW-1:0]   elem_in;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [CW-1:0]   cnt_base;
	logic            room;
	logic [CW-1:0]   cnt_next;
	logic [CW:0]     j_cur;
	logic [CW:0]     j_inc;
	logic [CW-1:0]   i_inc;
	logic            pair_ok;
	logic            pair_ok_inc;
	logic            do_swap;
	logic [XW-1:0]   gap_x10;
	logic [XW-1:0]   q_est;
	logic [XW-1:0]   rem_est;
	logic [XW-1:0]   q_fix;
	logic [XW-1:0]   q_rule;
	logic [CW-1:0]   gap_new;

	// input transaction decode
	assign s_axis_tready = (state_q == ST_IDLE) && !rd_pend_q && (!out_valid_q || m_axis_tready);
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign is_load = acc && (s_axis_tuser == FUNC_LOAD);
	assign is_read = acc && (s_axis_tuser == FUNC_READ);
	assign elem_in = s_axis_tdata[EW-1:0];
	assign idx_ext = CMP_W'(s_axis_tdata[EW+IDX_W-1:EW]);
	assign cnt_ext = CMP_W'(cnt_q);

	// append position, a new set restarts at zero
	assign cnt_base = start_q ? '0 : cnt_q;
	assign room     = cnt_base < CW'(MAX_ELEMENTS);
	assign cnt_next = room ? cnt_base + CW'(1) : cnt_base;

	// pair addressing for the current pass
	assign j_cur       = {1'b0, i_q} + {1'b0, gap_q};
	assign j_inc       = j_cur + (CW+1)'(1);
	assign i_inc       = i_q + CW'(1);
	assign pair_ok     = j_cur < {1'b0, cnt_q};
	assign pair_ok_inc = j_inc < {1'b0, cnt_q};
	assign do_swap     = $signed(ram_rdata_a) > $signed(ram_rdata_b);

	// gap shrink: gap*10/13 by reciprocal, one correction step
	assign gap_x10 = XW'(gap_q) * XW'(GAP_NUM);
	assign q_est   = prod_s1[2*XW-1:XW];
	assign rem_est = gap_x10 - XW'(q_est * XW'(GAP_DEN));
	assign q_fix   = (rem_est >= XW'(GAP_DEN)) ? q_est + XW'(1) : q_est;

	// rule of eleven and floor of one
	always_comb begin
		q_rule = q_fix;
		if (q_fix == XW'(GAP_SKIP_A) || q_fix == XW'(GAP_SKIP_B)) begin
			q_rule = XW'(GAP_ELEVEN);
		end
		if (q_fix == '0) begin
			q_rule = XW'(1);
		end
	end
	assign gap_new = q_rule[CW-1:0];

	// next state and RAM port control
	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_waddr   = cnt_base[AW-1:0];
		ram_wdata   = elem_in;
		ram_raddr_a = i_q[AW-1:0];
		ram_raddr_b = j_cur[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (is_read) begin
					ram_raddr_a = idx_ext[AW-1:0];
				end
				if (is_load) begin
					ram_we = room;
					if (s_axis_tlast) begin
						state_d = ST_SHRINK_MUL;
					end
				end
			end
			ST_SHRINK_MUL: begin
				state_d = ST_SHRINK_FIX;
			end
			ST_SHRINK_FIX: begin
				state_d = ST_PASS;
			end
			ST_PASS: begin
				if (pair_ok) begin
					state_d = ST_CMP;
				end else if (gap_q == CW'(1) && !swapped_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SHRINK_MUL;
				end
			end
			ST_CMP: begin
				if (do_swap) begin
					ram_we    = 1'b1;
					ram_waddr = i_q[AW-1:0];
					ram_wdata = ram_rdata_b;
					state_d   = ST_WRJ;
				end else if (pair_ok_inc) begin
					ram_raddr_a = i_inc[AW-1:0];
					ram_raddr_b = j_inc[AW-1:0];
				end else begin
					state_d = ST_PASS;
				end
			end
			ST_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_cur[AW-1:0];
				ram_wdata = hold_q;
				state_d   = ST_PASS;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// set bookkeeping and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			start_q   <= 1'b1;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (is_load) begin
				cnt_q   <= cnt_next;
				start_q <= s_axis_tlast;
			end
			rd_pend_q <= is_read;
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sort datapath and output payload
	always_ff @(posedge clk) begin
		prod_s1 <= (2*XW)'(gap_x10) * (2*XW)'(RECIP);
		if (is_load) begin
			gap_q <= cnt_next;
		end
		if (is_read) begin
			rd_oor_q <= !(idx_ext < cnt_ext);
		end
		if (state_q == ST_SHRINK_FIX) begin
			gap_q     <= gap_new;
			i_q       <= '0;
			swapped_q <= 1'b0;
		end
		if (state_q == ST_CMP) begin
			if (do_swap) begin
				hold_q    <= ram_rdata_a;
				swapped_q <= 1'b1;
			end else begin
				i_q <= i_inc;
			end
		end
		if (state_q == ST_WRJ) begin
			i_q <= i_inc;
		end
		if (rd_pend_q) begin
			out_data_q <= rd_oor_q ? '0 : ram_rdata_a;
			out_oor_q  <= rd_oor_q;
		end
	end

	// element store
	cs11_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	// result channel
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);
	assign m_axis_tuser  = out_oor_q;

	// checks
	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(MAX_ELEMENTS), "loaded count beyond capacity")
	`ASSERT_IMPLIES(a_sort_write_in_set, ram_we && state_q != ST_IDLE, CW'(ram_waddr) < cnt_q, "sort write outside loaded set")
	`ASSERT_IMPLIES(a_gap_nonzero, state_q == ST_CMP || state_q == ST_WRJ, gap_q != '0, "zero gap in pass")
	`ASSERT_IMPLIES(a_read_slot_free, rd_pend_q, !out_valid_q, "read data arrives at a full output register")

endmodule

/* rtl/core/cs11_ram.sv */
// ----------------------------------------------------------------------------
// cs11_ram
// Generic RAM: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module cs11_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
